>>> hw/rtl/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener package
// Request and segment payload types, fixed-point widths and the output
// saturation helper shared by the flattener RTL.
// ----------------------------------------------------------------------------
package cbf_pkg;

    // Field widths of the request and segment payloads.
    localparam int COORD_W = 24;
    localparam int WIDTH_W = 16;
    localparam int RGBA_W  = 32;

    // Bernstein weights are unsigned Q.24 with one integer bit, so 1.0 is exact.
    localparam int WGT_W      = 25;
    localparam int FRAC_SHIFT = 24;
    // Signed weight (WGT_W + 1) times a signed coordinate.
    localparam int PROD_W     = WGT_W + 1 + COORD_W;
    // Sum of four products plus the rounding half, with headroom.
    localparam int SUM_W      = PROD_W + 2;
    // Rounded coordinate before saturation.
    localparam int FULL_W     = SUM_W - FRAC_SHIFT;

    // One in unsigned Q0.16, and one half in Q.24 for weight rounding.
    localparam longint unsigned ONE_Q16  = 64'd65536;
    localparam longint unsigned HALF_Q24 = 64'd8388608;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [3:0][WGT_W-1:0]     wgt4_t;

    // One curve request.
    typedef struct packed {
        logic signed [COORD_W-1:0] ctrl_p0_x;
        logic signed [COORD_W-1:0] ctrl_p0_y;
        logic signed [COORD_W-1:0] ctrl_p1_x;
        logic signed [COORD_W-1:0] ctrl_p1_y;
        logic signed [COORD_W-1:0] ctrl_p2_x;
        logic signed [COORD_W-1:0] ctrl_p2_y;
        logic signed [COORD_W-1:0] ctrl_p3_x;
        logic signed [COORD_W-1:0] ctrl_p3_y;
        logic [WIDTH_W-1:0]        stroke_width;
        logic [RGBA_W-1:0]         stroke_rgba;
    } cmd_t;

    // One line segment.
    typedef struct packed {
        logic signed [COORD_W-1:0] seg_start_x;
        logic signed [COORD_W-1:0] seg_start_y;
        logic signed [COORD_W-1:0] seg_end_x;
        logic signed [COORD_W-1:0] seg_end_y;
        logic [WIDTH_W-1:0]        seg_width;
        logic [RGBA_W-1:0]         seg_rgba;
        logic                      seg_last;
    } seg_t;

    // Side data that travels down the pipeline with each step.
    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic [WIDTH_W-1:0]        width;
        logic [RGBA_W-1:0]         rgba;
        logic                      first;
        logic                      last;
    } meta_t;

    // Clamp a rounded coordinate to the signed Q16.8 range.
    function automatic coord_t sat_coord(input logic signed [FULL_W-1:0] v);
        logic signed [FULL_W-1:0] hi;
        logic signed [FULL_W-1:0] lo;
        hi = FULL_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = -hi - FULL_W'(1);
        if (v > hi)
        begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

>>> hw/rtl/cubic_bezier_flattener_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener
// Turns each curve request into SEGMENTS chained line segments.
//
// A request carries four signed Q16.8 control points, a stroke width and a
// packed color. The block samples the curve at t = i/SEGMENTS, i = 1..SEGMENTS,
// and emits one segment per cycle while seg_stall is low, from the previous
// sample (p0 first) to the new one, with width and color copied and seg_last
// set on the final segment. Sample points are rounded and saturated to the
// Q16.8 range. The step sequencer issues one sample per cycle unless the
// output stalls, and takes a new request in its last step, so curves run
// back to back. Each sample passes weight lookup, multiply, pair add and a
// final add with round and saturate before its segment is registered.
// The Bernstein weights are constants built at elaboration from SEGMENTS.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_top
    import cbf_pkg::*;
#(
    parameter int SEGMENTS = 20
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic seg_valid,
    input  logic seg_stall,
    output seg_t seg
);

    localparam int STEP_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    // Weights for sample index idx: u^3, 3u^2t, 3ut^2, t^3, rounded to Q.24.
    function automatic wgt4_t weight_of(input int unsigned idx);
        longint unsigned t;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t2;
        wgt4_t w;
        t = (64'(idx) * ONE_Q16 + 64'(SEGMENTS / 2)) / 64'(SEGMENTS);
        if (t > ONE_Q16)
        begin
            t = ONE_Q16;
        end
        u  = ONE_Q16 - t;
        u2 = u * u;
        t2 = t * t;
        w[0] = WGT_W'((u2 * u + HALF_Q24) >> FRAC_SHIFT);
        w[1] = WGT_W'((64'd3 * u2 * t + HALF_Q24) >> FRAC_SHIFT);
        w[2] = WGT_W'((64'd3 * u * t2 + HALF_Q24) >> FRAC_SHIFT);
        w[3] = WGT_W'((t2 * t + HALF_Q24) >> FRAC_SHIFT);
        return w;
    endfunction

    // Constant weight lookup, one entry per step.
    wgt4_t wgt_tab [SEGMENTS];

    for (genvar g = 0; g < SEGMENTS; g++)
    begin : g_wgt
        assign wgt_tab[g] = weight_of(g + 1);
    end

    // Whole pipeline moves unless the output holds a stalled segment.
    logic advance;
    logic accept;
    logic step_last;

    // Step sequencer state.
    cmd_t              cmd_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;

    // Stage 1: weights and points.
    logic   s1_valid_reg;
    wgt4_t  s1_wgt_reg;
    coord_t s1_px_reg [4];
    coord_t s1_py_reg [4];
    meta_t  s1_meta_reg;

    // Stage 2: products.
    logic   s2_valid_reg;
    prod_t  s2_prod_x_reg [4];
    prod_t  s2_prod_y_reg [4];
    meta_t  s2_meta_reg;

    // Stage 3: pair sums, rounding half folded into the first pair.
    logic   s3_valid_reg;
    sum_t   s3_pair_x_reg [2];
    sum_t   s3_pair_y_reg [2];
    meta_t  s3_meta_reg;

    // Output stage.
    logic   seg_valid_reg;
    seg_t   seg_reg;
    coord_t last_end_x_reg;
    coord_t last_end_y_reg;

    // Final sum, round and saturate.
    sum_t   total_x;
    sum_t   total_y;
    coord_t end_x;
    coord_t end_y;
    seg_t   seg_next;

    // Handshake control.
    assign advance   = !seg_valid_reg || !seg_stall;
    assign step_last = (step_reg == STEP_W'(SEGMENTS - 1));
    assign cmd_stall = busy_reg && !(advance && step_last);
    assign accept    = cmd_valid && !cmd_stall;

    // Step sequencer: holds the current curve and counts its samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg && advance)
        begin
            if (step_last)
            begin
                busy_reg <= 1'b0;
                step_reg <= '0;
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            seg_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= busy_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            seg_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: look up the weights of this step and latch the points.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_wgt_reg   <= wgt_tab[step_reg];
            s1_px_reg[0] <= cmd_reg.ctrl_p0_x;
            s1_px_reg[1] <= cmd_reg.ctrl_p1_x;
            s1_px_reg[2] <= cmd_reg.ctrl_p2_x;
            s1_px_reg[3] <= cmd_reg.ctrl_p3_x;
            s1_py_reg[0] <= cmd_reg.ctrl_p0_y;
            s1_py_reg[1] <= cmd_reg.ctrl_p1_y;
            s1_py_reg[2] <= cmd_reg.ctrl_p2_y;
            s1_py_reg[3] <= cmd_reg.ctrl_p3_y;
            s1_meta_reg.p0_x  <= cmd_reg.ctrl_p0_x;
            s1_meta_reg.p0_y  <= cmd_reg.ctrl_p0_y;
            s1_meta_reg.width <= cmd_reg.stroke_width;
            s1_meta_reg.rgba  <= cmd_reg.stroke_rgba;
            s1_meta_reg.first <= (step_reg == '0);
            s1_meta_reg.last  <= step_last;
        end
    end

    // Stage 2: eight weight-by-coordinate products.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s2_prod_x_reg[k] <= $signed({1'b0, s1_wgt_reg[k]}) * s1_px_reg[k];
                s2_prod_y_reg[k] <= $signed({1'b0, s1_wgt_reg[k]}) * s1_py_reg[k];
            end
            s2_meta_reg <= s1_meta_reg;
        end
    end

    // Stage 3: pair sums.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_pair_x_reg[0] <= sum_t'(s2_prod_x_reg[0]) + sum_t'(s2_prod_x_reg[1])
                                + sum_t'(HALF_Q24);
            s3_pair_x_reg[1] <= sum_t'(s2_prod_x_reg[2]) + sum_t'(s2_prod_x_reg[3]);
            s3_pair_y_reg[0] <= sum_t'(s2_prod_y_reg[0]) + sum_t'(s2_prod_y_reg[1])
                                + sum_t'(HALF_Q24);
            s3_pair_y_reg[1] <= sum_t'(s2_prod_y_reg[2]) + sum_t'(s2_prod_y_reg[3]);
            s3_meta_reg <= s2_meta_reg;
        end
    end

    // Final add; with the half added in stage 3, dropping the fraction bits rounds to nearest, halves up.
    always_comb
    begin
        total_x = s3_pair_x_reg[0] + s3_pair_x_reg[1];
        total_y = s3_pair_y_reg[0] + s3_pair_y_reg[1];
        end_x   = sat_coord(total_x[SUM_W-1:FRAC_SHIFT]);
        end_y   = sat_coord(total_y[SUM_W-1:FRAC_SHIFT]);

        seg_next.seg_start_x = s3_meta_reg.first ? s3_meta_reg.p0_x : last_end_x_reg;
        seg_next.seg_start_y = s3_meta_reg.first ? s3_meta_reg.p0_y : last_end_y_reg;
        seg_next.seg_end_x   = end_x;
        seg_next.seg_end_y   = end_y;
        seg_next.seg_width   = s3_meta_reg.width;
        seg_next.seg_rgba    = s3_meta_reg.rgba;
        seg_next.seg_last    = s3_meta_reg.last;
    end

    // Output register; the end point is kept to start the next segment.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seg_reg <= seg_next;
            if (s3_valid_reg)
            begin
                last_end_x_reg <= end_x;
                last_end_y_reg <= end_y;
            end
        end
    end

    assign seg_valid = seg_valid_reg;
    assign seg       = seg_reg;

    // A new request starts the sequencer at its first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg && step_reg == '0))
        else $error("sequencer did not restart on a new request");

    // The sequencer goes idle after its last step when nothing new arrives.
    a_last_step_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_last && advance && !cmd_valid) |=> !busy_reg)
        else $error("sequencer stayed busy after the last step");

    // A chained segment starts where the previous one ended.
    a_chain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg && !s3_meta_reg.first)
        |=> (seg_reg.seg_start_x == $past(last_end_x_reg)
             && seg_reg.seg_start_y == $past(last_end_y_reg)))
        else $error("segment start does not match previous end");

    // The pipeline never issues a step while the sequencer is idle.
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !busy_reg) |=> !s1_valid_reg)
        else $error("step issued while sequencer idle");

endmodule

>>> sim/cbf_segment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener segment checker
// Watches the request and segment channels of the flattener. For every
// accepted curve request it computes the chained line segments in fixed
// point and queues them. Each accepted segment is then compared field by
// field against the oldest queued segment.
// ----------------------------------------------------------------------------
module cbf_segment_checker
    import cbf_pkg::*;
#(
    parameter int SEGMENTS = 20
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_stall,
    input  cmd_t cmd,
    input  logic seg_valid,
    input  logic seg_stall,
    input  seg_t seg,
    output int   mismatches,
    output int   outstanding
);

    // Fixed-point constants: 1.0 in Q0.16, one half in Q.24, Q16.8 limits.
    localparam longint UNIT_T     = 64'sd65536;
    localparam longint ROUND_HALF = 64'sd8388608;
    localparam longint COORD_HI   = 64'sd8388607;
    localparam longint COORD_LO   = -64'sd8388608;

    seg_t expected_segs_q[$];
    int   mismatch_count;

    // Weighted sum of four coordinates in Q.32, rounded to Q16.8 with halves
    // going up, then clamped to the coordinate range.
    function automatic longint blend_coord(input longint w0, input longint w1,
                                           input longint w2, input longint w3,
                                           input longint p0, input longint p1,
                                           input longint p2, input longint p3);
        longint acc;
        longint r;
        acc = w0 * p0 + w1 * p1 + w2 * p2 + w3 * p3;
        r = (acc + ROUND_HALF) >>> 24;
        if (r > COORD_HI)
        begin
            r = COORD_HI;
        end
        if (r < COORD_LO)
        begin
            r = COORD_LO;
        end
        return r;
    endfunction

    // Expands one curve request into its segments and queues them.
    function automatic void flatten_curve(input cmd_t c);
        longint px[4];
        longint py[4];
        longint t;
        longint u;
        longint w0;
        longint w1;
        longint w2;
        longint w3;
        longint from_x;
        longint from_y;
        longint to_x;
        longint to_y;
        seg_t   s;
        int     i;
        px[0] = longint'(c.ctrl_p0_x);
        py[0] = longint'(c.ctrl_p0_y);
        px[1] = longint'(c.ctrl_p1_x);
        py[1] = longint'(c.ctrl_p1_y);
        px[2] = longint'(c.ctrl_p2_x);
        py[2] = longint'(c.ctrl_p2_y);
        px[3] = longint'(c.ctrl_p3_x);
        py[3] = longint'(c.ctrl_p3_y);
        from_x = px[0];
        from_y = py[0];
        for (i = 1; i <= SEGMENTS; i++)
        begin
            // Sample position t = i/SEGMENTS in Q0.16, rounded to nearest.
            t = (longint'(i) * UNIT_T + longint'(SEGMENTS / 2)) / longint'(SEGMENTS);
            if (t > UNIT_T)
            begin
                t = UNIT_T;
            end
            u = UNIT_T - t;
            w0 = (u * u * u + ROUND_HALF) >>> 24;
            w1 = (3 * u * u * t + ROUND_HALF) >>> 24;
            w2 = (3 * u * t * t + ROUND_HALF) >>> 24;
            w3 = (t * t * t + ROUND_HALF) >>> 24;
            to_x = blend_coord(w0, w1, w2, w3, px[0], px[1], px[2], px[3]);
            to_y = blend_coord(w0, w1, w2, w3, py[0], py[1], py[2], py[3]);
            s.seg_start_x = coord_t'(from_x);
            s.seg_start_y = coord_t'(from_y);
            s.seg_end_x   = coord_t'(to_x);
            s.seg_end_y   = coord_t'(to_y);
            s.seg_width   = c.stroke_width;
            s.seg_rgba    = c.stroke_rgba;
            s.seg_last    = (i == SEGMENTS);
            expected_segs_q = {expected_segs_q, s};
            // The next segment starts where this one ended, after clamping.
            from_x = to_x;
            from_y = to_y;
        end
    endfunction

    // Counts a differing field and prints it.
    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Segments are checked before a request is expanded, since a segment
    // can never belong to a request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        seg_t want;
        if (!rst_n)
        begin
            expected_segs_q.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (seg_valid && !seg_stall)
            begin
                if (expected_segs_q.size() == 0)
                begin
                    $display("%0t ns: unexpected segment, expected none, actual %h",
                             $time, seg);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_segs_q.pop_front();
                    check_field("seg_start_x", longint'(want.seg_start_x),
                                longint'(seg.seg_start_x));
                    check_field("seg_start_y", longint'(want.seg_start_y),
                                longint'(seg.seg_start_y));
                    check_field("seg_end_x", longint'(want.seg_end_x),
                                longint'(seg.seg_end_x));
                    check_field("seg_end_y", longint'(want.seg_end_y),
                                longint'(seg.seg_end_y));
                    check_field("seg_width", longint'(want.seg_width),
                                longint'(seg.seg_width));
                    check_field("seg_rgba", longint'(want.seg_rgba),
                                longint'(seg.seg_rgba));
                    check_field("seg_last", longint'(want.seg_last),
                                longint'(seg.seg_last));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                flatten_curve(cmd);
            end
        end
        mismatches  = mismatch_count;
        outstanding = expected_segs_q.size();
    end

endmodule

>>> sim/cubic_bezier_flattener_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener testbench
// Sends a directed set of curve requests (range extremes, saturating
// overshoot, degenerate and straight curves) followed by random curves,
// with random request gaps and random segment stalls. The segment checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_top_tb;
    import cbf_pkg::*;

    localparam int SEGMENTS     = 20;
    localparam int RANDOM_ITEMS = 395;

    localparam coord_t C_MAX  = 24'sh7FFFFF;
    localparam coord_t C_MIN  = 24'sh800000;
    localparam coord_t C_ZERO = 24'sh000000;
    localparam coord_t C_NEG1 = 24'shFFFFFF;
    localparam coord_t C_A5   = 24'sh555555;
    localparam coord_t C_5A   = 24'shAAAAAA;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic seg_valid;
    logic seg_stall = 1'b0;
    seg_t seg;
    int   mismatches;
    int   outstanding;

    // Receiver stall state.
    int   stall_left = 0;
    int   stall_mode = 0;
    int   mode_left = 0;
    // Sender runs stretches of back-to-back requests when this is set.
    bit   burst_mode = 1'b0;

    cubic_bezier_flattener_top #(
        .SEGMENTS (SEGMENTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg)
    );

    cbf_segment_checker #(
        .SEGMENTS (SEGMENTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .seg         (seg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Segment stalls: the mode changes now and then between none, short
    // sparse stalls and heavy stalls that include a few long ones.
    always @(negedge clk)
    begin
        logic next_stall;
        next_stall = 1'b0;
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 400);
        end
        else
        begin
            mode_left--;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            next_stall = 1'b1;
        end
        else if (stall_mode == 1 && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            next_stall = 1'b1;
        end
        else if (stall_mode == 2 && $urandom_range(0, 1) == 0)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(10, 40);
            end
            else
            begin
                stall_left = $urandom_range(0, 3);
            end
            next_stall = 1'b1;
        end
        seg_stall <= next_stall;
    end

    function automatic cmd_t make_curve(input coord_t x0, input coord_t y0,
                                        input coord_t x1, input coord_t y1,
                                        input coord_t x2, input coord_t y2,
                                        input coord_t x3, input coord_t y3,
                                        input logic [15:0] wd,
                                        input logic [31:0] rgba);
        cmd_t c;
        c.ctrl_p0_x    = x0;
        c.ctrl_p0_y    = y0;
        c.ctrl_p1_x    = x1;
        c.ctrl_p1_y    = y1;
        c.ctrl_p2_x    = x2;
        c.ctrl_p2_y    = y2;
        c.ctrl_p3_x    = x3;
        c.ctrl_p3_y    = y3;
        c.stroke_width = wd;
        c.stroke_rgba  = rgba;
        return c;
    endfunction

    // Mostly full-range coordinates, with small values and values at or
    // near the limits mixed in so saturation is hit often.
    function automatic coord_t random_coord();
        coord_t v;
        case ($urandom_range(0, 9))
            6, 7:    v = coord_t'(int'($urandom_range(0, 2048)) - 1024);
            8:       v = ($urandom_range(0, 1) == 0) ? C_MAX : C_MIN;
            9:       v = ($urandom_range(0, 1) == 0) ?
                         C_MAX - coord_t'($urandom_range(0, 255)) :
                         C_MIN + coord_t'($urandom_range(0, 255));
            default: v = coord_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic cmd_t random_curve();
        return make_curve(random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(), random_coord(),
                          random_coord(), random_coord(),
                          16'($urandom), 32'($urandom));
    endfunction

    // Idle cycles before the next request: mostly none or a few, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (burst_mode || roll < 5)
        begin
            return 0;
        end
        else if (roll < 9)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    // Presents one request after the given gap and holds it until accepted.
    task automatic send_curve(input cmd_t c, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Run limit, well above the slowest legal run.
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int n;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed curves: all zero, all at either limit (weight rounding
        // overshoots and must saturate), alternating limits, bit patterns,
        // a straight line, a tiny curve, a closed loop and a full swing.
        send_curve(make_curve(C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                              C_ZERO, C_ZERO, 16'h0000, 32'h0000_0000), 0);
        send_curve(make_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                              C_MAX, C_MAX, 16'hFFFF, 32'hFFFF_FFFF), 0);
        send_curve(make_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                              C_MIN, C_MIN, 16'hFFFF, 32'h0000_0000), 0);
        send_curve(make_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                              C_MAX, C_MIN, 16'h0000, 32'hFFFF_FFFF), 0);
        send_curve(make_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                              C_MIN, C_MAX, 16'h8000, 32'h8000_0001), 0);
        send_curve(make_curve(C_MAX, C_MAX, C_ZERO, C_ZERO, C_ZERO, C_ZERO,
                              C_MIN, C_MIN, 16'h0001, 32'h7FFF_FFFE), 0);
        send_curve(make_curve(C_A5, C_5A, C_5A, C_A5, C_A5, C_5A,
                              C_5A, C_A5, 16'h5555, 32'h5555_5555), 0);
        send_curve(make_curve(C_5A, C_A5, C_A5, C_5A, C_5A, C_A5,
                              C_A5, C_5A, 16'hAAAA, 32'hAAAA_AAAA), 0);
        send_curve(make_curve(C_ZERO, C_ZERO, 24'sd8533, -24'sd4267,
                              24'sd17067, -24'sd8533, 24'sd25600, -24'sd12800,
                              16'h0180, 32'hFF00_00FF), 0);
        send_curve(make_curve(C_NEG1, C_NEG1, C_ZERO, 24'sd1, 24'sd1, C_ZERO,
                              24'sd1, 24'sd1, 16'h0100, 32'h0102_0304), 0);
        send_curve(make_curve(24'sd1000, 24'sd1000, 24'sd90000, -24'sd50000,
                              -24'sd90000, -24'sd50000, 24'sd1000, 24'sd1000,
                              16'h0200, 32'h00FF_FF00), 0);
        send_curve(make_curve(C_MIN, C_ZERO, C_MAX, C_MAX, C_MIN, C_MIN,
                              C_MAX, C_ZERO, 16'h7FFF, 32'hDEAD_BEEF), 0);
        send_curve(make_curve(C_MAX - 24'sd1, C_MIN + 24'sd1, C_MAX, C_MIN,
                              C_MAX, C_MIN, C_MAX - 24'sd1, C_MIN + 24'sd1,
                              16'hFFFE, 32'h0000_0001), 0);
        // One random curve sent back to back and one sent after a gap.
        send_curve(random_curve(), 0);
        send_curve(random_curve(), 7);

        // Random curves with random gaps and occasional burst stretches.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 30 == 0)
            begin
                burst_mode = ($urandom_range(0, 2) == 0);
            end
            send_curve(random_curve(), pick_gap());
        end

        @(negedge clk);
        cmd_valid <= 1'b0;

        // Drain the remaining segments, then allow for the pipeline depth.
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SEGMENTS + 8) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cbf_pkg.sv
hw/rtl/cubic_bezier_flattener_top.sv
sim/cbf_segment_checker.sv
sim/cubic_bezier_flattener_top_tb.sv
